// ----- rtl/core/tlssni_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tlssni_pkg;

  localparam int unsigned NameBufBytes = 256;
  localparam logic [11:0] NameBufLimit = 12'(NameBufBytes - 1);

  localparam logic [7:0] ContentHandshake = 8'h16;
  localparam logic [7:0] HsClientHello    = 8'h01;
  localparam logic [7:0] HsServerHello    = 8'h02;
  localparam logic [7:0] HsCertificate    = 8'h0b;
  localparam logic [15:0] RandomSkip      = 16'd34;
  localparam logic [15:0] OidPrefix       = 16'h5504;
  localparam logic [7:0] OidLast          = 8'h03;

  localparam logic [0:0] CfgMaxRecordLen = 1'b0;
  localparam logic [0:0] CfgMaxNameLen   = 1'b1;
  localparam logic [14:0] MaxRecordLenRst = 15'd4095;
  localparam logic [11:0] MaxNameLenRst   = 12'd255;

  localparam logic [1:0] StError      = 2'd0;
  localparam logic [1:0] StIncomplete = 2'd1;
  localparam logic [1:0] StNoName     = 2'd2;
  localparam logic [1:0] StNameFound  = 2'd3;

  // Hi phases are followed directly by their Lo phase (next code is one shift up)
  typedef enum logic [22:0] {
    PhHdr     = 23'h000001,
    PhHs      = 23'h000002,
    PhSkip    = 23'h000004,
    PhSidLen  = 23'h000008,
    PhCsHi    = 23'h000010,
    PhCsLo    = 23'h000020,
    PhCmLen   = 23'h000040,
    PhExtsHi  = 23'h000080,
    PhExtsLo  = 23'h000100,
    PhEtHi    = 23'h000200,
    PhEtLo    = 23'h000400,
    PhElHi    = 23'h000800,
    PhElLo    = 23'h001000,
    PhListHi  = 23'h002000,
    PhListLo  = 23'h004000,
    PhNtype   = 23'h008000,
    PhNlHi    = 23'h010000,
    PhNlLo    = 23'h020000,
    PhEmit    = 23'h040000,
    PhScan    = 23'h080000,
    PhCnTag   = 23'h100000,
    PhCnLen   = 23'h200000,
    PhDone    = 23'h400000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       flow_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_valid;
    logic       name_last;
    logic       status_valid;
    logic [1:0] parse_status;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/tls_hello_sni_extractor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Extracts the TLS SNI host name (ClientHello) or second certificate common
// name (ServerHello/Certificate) from a byte stream. One byte per cycle when
// not stalled; each request yields one result in the cycle after acceptance,
// set by one registered parse-state update. No clearing pass after reset.
module tls_hello_sni_extractor_unit (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire tlssni_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output tlssni_pkg::out_item_t   out_data_o,
  input  wire                     cfg_we_i,
  input  wire  [0:0]              cfg_index_i,
  input  wire  [14:0]             cfg_data_i
);
  import tlssni_pkg::*;

  logic [14:0] max_rec_q;
  logic [11:0] max_name_q;
  phase_e      ph_q, ph_d;
  phase_e      tstep_q, tstep_d;
  logic [14:0] rlen_q, rlen_d, pos_q, pos_d, nstart_q, nstart_d;
  logic [15:0] skip_q, skip_d, l2_q, l2_d;
  logic [7:0]  hi_q, hi_d;
  logic [11:0] nlen_q, nlen_d;
  logic [1:0]  seen_q, seen_d;
  logic        emitted_q, emitted_d, err_q, err_d;
  out_item_t   res_d;
  logic        acc, out_free;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = !out_free;
  assign acc        = in_valid_i && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rec_q  <= MaxRecordLenRst;
      max_name_q <= MaxNameLenRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMaxRecordLen) max_rec_q <= cfg_data_i;
      else max_name_q <= cfg_data_i[11:0];
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] w;
    logic [16:0] endp;
    logic [11:0] lim;
    logic [15:0] n;
    logic [1:0]  seen_n;
    logic        do_name, do_skip;
    logic [15:0] skn;
    phase_e      skto;
    logic [14:0] pos;
    b = in_data_i.data_byte;
    ph_d = ph_q; tstep_d = tstep_q; rlen_d = rlen_q; pos_d = pos_q;
    skip_d = skip_q; hi_d = hi_q; l2_d = l2_q; nstart_d = nstart_q;
    nlen_d = nlen_q; seen_d = seen_q; emitted_d = emitted_q; err_d = err_q;
    if (in_data_i.flow_start) begin
      ph_d = PhHdr; tstep_d = PhHdr; rlen_d = '0; pos_d = '0; skip_d = '0;
      hi_d = '0; l2_d = '0; nstart_d = '0; nlen_d = '0; seen_d = '0;
      emitted_d = 1'b0; err_d = 1'b0;
    end
    pos = pos_d;
    res_d = '0;
    res_d.status_valid = in_data_i.chunk_end;
    w = {hi_d, b};
    lim = (max_name_q > NameBufLimit) ? NameBufLimit : max_name_q;
    do_name = 1'b0; do_skip = 1'b0; n = '0; skn = '0; skto = PhHdr;
    seen_n = seen_d;
    endp = '0;
    if (!err_d && ph_d != PhDone) begin
      pos_d = pos_d + 15'd1;
      case (ph_d)
        PhHdr: begin
          if (pos == 15'd0 && b != ContentHandshake) begin
            err_d = 1'b1; ph_d = PhDone;
          end else if (pos == 15'd3) begin
            hi_d = b;
          end else if (pos >= 15'd4) begin
            if ({1'b0, w} + 17'd5 < 17'd9 || {1'b0, w} + 17'd5 > {2'b0, max_rec_q}) begin
              err_d = 1'b1; ph_d = PhDone;
            end else begin
              rlen_d = 15'(w + 16'd5); ph_d = PhHs;
            end
          end
        end
        PhHs: begin
          if (pos == 15'd5) begin
            if (b == HsClientHello) tstep_d = PhSidLen;
            else if (b == HsServerHello || b == HsCertificate) tstep_d = PhScan;
            else ph_d = PhDone;
          end else if (pos >= 15'd8) begin
            if (tstep_d == PhScan) begin
              l2_d = '0; ph_d = PhScan;
            end else begin
              do_skip = 1'b1; skn = RandomSkip; skto = PhSidLen;
            end
          end
        end
        PhSkip: begin
          skip_d = skip_q - 16'd1;
          if (skip_d == 16'd0) ph_d = tstep_q;
        end
        PhSidLen: begin do_skip = 1'b1; skn = {8'd0, b}; skto = PhCsHi; end
        PhCsHi, PhExtsHi, PhEtHi, PhElHi, PhListHi, PhNlHi: begin
          hi_d = b; ph_d = phase_e'(ph_q << 1);
        end
        PhCsLo: begin do_skip = 1'b1; skn = w; skto = PhCmLen; end
        PhCmLen: begin do_skip = 1'b1; skn = {8'd0, b}; skto = PhExtsHi; end
        PhExtsLo: begin
          endp = {2'b0, pos} + 17'd1 + {1'b0, w};
          if (endp > {2'b0, rlen_q}) begin err_d = 1'b1; ph_d = PhDone; end
          else if (w == 16'd0) ph_d = PhDone;
          else ph_d = PhEtHi;
        end
        PhEtLo: begin l2_d = w; ph_d = PhElHi; end
        PhElLo: begin
          if (l2_q == 16'd0) ph_d = PhListHi;
          else begin do_skip = 1'b1; skn = w; skto = PhEtHi; end
        end
        PhListLo: ph_d = PhNtype;
        PhNtype: ph_d = (b == 8'd0) ? PhNlHi : PhDone;
        PhNlLo: begin do_name = 1'b1; n = w; end
        PhEmit: begin
          res_d.name_byte = b; res_d.name_valid = 1'b1;
          if ({1'b0, pos - nstart_q} + 16'd1 >= {4'd0, nlen_q}) begin
            res_d.name_last = 1'b1; emitted_d = 1'b1; ph_d = PhDone;
          end
        end
        PhScan: begin
          if (l2_q == OidPrefix && b == OidLast) begin
            l2_d = '0; ph_d = PhCnTag;
          end else l2_d = {l2_q[7:0], b};
        end
        PhCnTag: ph_d = PhCnLen;
        PhCnLen: begin
          if (seen_q != 2'd3) seen_n = seen_q + 2'd1;
          seen_d = seen_n;
          if (seen_n == 2'd1) begin do_skip = 1'b1; skn = {8'd0, b}; skto = PhScan; end
          else begin do_name = 1'b1; n = {8'd0, b}; end
        end
        default: begin err_d = 1'b1; ph_d = PhDone; end
      endcase
      if (do_skip) begin
        tstep_d = skto; skip_d = skn;
        ph_d = (skn == 16'd0) ? skto : PhSkip;
      end
      if (do_name) begin
        endp = {2'b0, pos} + 17'd1 + {1'b0, n};
        if (n == 16'd0) ph_d = PhDone;
        else if (n > {4'd0, lim} || endp > {2'b0, rlen_q}) begin
          err_d = 1'b1; ph_d = PhDone;
        end else begin
          nlen_d = n[11:0]; nstart_d = pos + 15'd1; ph_d = PhEmit;
        end
      end
      if (!err_d && ph_d != PhHdr && ph_d != PhDone && pos_d >= rlen_d) ph_d = PhDone;
    end
    if (in_data_i.chunk_end) begin
      if (err_d) res_d.parse_status = StError;
      else if (ph_d == PhDone) res_d.parse_status = emitted_d ? StNameFound : StNoName;
      else res_d.parse_status = StIncomplete;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhHdr; tstep_q <= PhHdr; rlen_q <= '0; pos_q <= '0; skip_q <= '0;
      hi_q <= '0; l2_q <= '0; nstart_q <= '0; nlen_q <= '0; seen_q <= '0;
      emitted_q <= 1'b0; err_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      if (out_free) out_valid_o <= in_valid_i;
      if (acc) begin
        ph_q <= ph_d; tstep_q <= tstep_d; rlen_q <= rlen_d; pos_q <= pos_d;
        skip_q <= skip_d; hi_q <= hi_d; l2_q <= l2_d; nstart_q <= nstart_d;
        nlen_q <= nlen_d; seen_q <= seen_d; emitted_q <= emitted_d; err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_data_o <= res_d;
  end

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> ph_q == PhDone) else $error("error without done");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.name_last |-> out_data_o.name_valid)
    else $error("last without valid");
  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhEmit |-> nlen_q != 12'd0) else $error("zero name length");
endmodule
`default_nettype wire

// ----- tb/sv/tls_hello_sni_extractor_unit_test.sv -----
`timescale 1ns / 1ps
module tls_hello_sni_extractor_unit_test;
  import tlssni_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = CfgMaxRecordLen;
  logic [14:0] cfg_data_i = '0;

  tls_hello_sni_extractor_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // parser copy
  logic [14:0] lim_record;
  logic [11:0] lim_name;
  phase_e      phase;
  phase_e      next_step;
  logic [14:0] rec_len;
  logic [14:0] byte_pos;
  logic [15:0] skip_cnt;
  logic [7:0]  len_hi;
  logic [15:0] prev_pair;
  logic [14:0] name_pos;
  logic [11:0] name_len;
  logic [1:0]  cn_count;
  logic        name_done;
  logic        err;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int  errors = 0;
  int  n_requests = 0;
  int  n_results = 0;
  int  n_names = 0;
  int  idle_mode = 0;
  int  stall_run = 0;
  bit  held_off = 1'b0;
  bit  in_done = 1'b0;
  int  quiet = 0;

  function automatic void clear_parser();
    phase = PhHdr; next_step = PhHdr; rec_len = '0; byte_pos = '0; skip_cnt = '0;
    len_hi = '0; prev_pair = '0; name_pos = '0; name_len = '0; cn_count = '0;
    name_done = 1'b0; err = 1'b0;
  endfunction

  function automatic void parse_fail();
    err = 1'b1;
    phase = PhDone;
  endfunction

  function automatic void go_skip(int unsigned n, phase_e nxt);
    next_step = nxt;
    skip_cnt = n[15:0];
    phase = (skip_cnt == 0) ? nxt : PhSkip;
  endfunction

  function automatic void open_name(int unsigned n, int unsigned pos);
    int unsigned lim;
    lim = 32'((lim_name > NameBufLimit) ? NameBufLimit : lim_name);
    if (n == 0) phase = PhDone;
    else if (n > lim || pos + 1 + n > rec_len) parse_fail();
    else begin
      name_len = n[11:0];
      name_pos = 15'(pos + 1);
      phase = PhEmit;
    end
  endfunction

  function automatic out_item_t sni_predict(in_item_t req);
    out_item_t r;
    int unsigned pos, w, b, len;
    r = '0;
    b = 32'(req.data_byte);
    if (req.flow_start) clear_parser();
    if (!err && phase != PhDone) begin
      pos = 32'(byte_pos);
      w = 32'({len_hi, req.data_byte});
      byte_pos = 15'(pos + 1);
      case (phase)
        PhHdr: begin
          if (pos == 0 && req.data_byte != ContentHandshake) parse_fail();
          else if (pos == 3) len_hi = req.data_byte;
          else if (pos >= 4) begin
            len = w + 5;
            if (len < 9 || len > lim_record) parse_fail();
            else begin
              rec_len = 15'(len);
              phase = PhHs;
            end
          end
        end
        PhHs: begin
          if (pos == 5) begin
            if (req.data_byte == HsClientHello) next_step = PhSidLen;
            else if (req.data_byte == HsServerHello || req.data_byte == HsCertificate)
              next_step = PhScan;
            else phase = PhDone;
          end else if (pos >= 8) begin
            if (next_step == PhScan) begin
              prev_pair = '0;
              phase = PhScan;
            end else go_skip(32'(RandomSkip), PhSidLen);
          end
        end
        PhSkip: begin
          skip_cnt = skip_cnt - 16'd1;
          if (skip_cnt == 0) phase = next_step;
        end
        PhSidLen: go_skip(b, PhCsHi);
        PhCsHi, PhExtsHi, PhEtHi, PhElHi, PhListHi, PhNlHi: begin
          len_hi = req.data_byte;
          phase = phase_e'(phase << 1);
        end
        PhCsLo: go_skip(w, PhCmLen);
        PhCmLen: go_skip(b, PhExtsHi);
        PhExtsLo: begin
          if (pos + 1 + w > rec_len) parse_fail();
          else if (w == 0) phase = PhDone;
          else phase = PhEtHi;
        end
        PhEtLo: begin
          prev_pair = w[15:0];
          phase = PhElHi;
        end
        PhElLo: begin
          if (prev_pair == 0) phase = PhListHi;
          else go_skip(w, PhEtHi);
        end
        PhListLo: phase = PhNtype;
        PhNtype: phase = (b == 0) ? PhNlHi : PhDone;
        PhNlLo: open_name(w, pos);
        PhEmit: begin
          r.name_byte = req.data_byte;
          r.name_valid = 1'b1;
          if (pos - name_pos + 1 >= name_len) begin
            r.name_last = 1'b1;
            name_done = 1'b1;
            phase = PhDone;
          end
        end
        PhScan: begin
          if (prev_pair == OidPrefix && req.data_byte == OidLast) begin
            prev_pair = '0;
            phase = PhCnTag;
          end else prev_pair = {prev_pair[7:0], req.data_byte};
        end
        PhCnTag: phase = PhCnLen;
        PhCnLen: begin
          if (cn_count < 3) cn_count = cn_count + 2'd1;
          if (cn_count == 1) go_skip(b, PhScan);
          else open_name(b, pos);
        end
        default: parse_fail();
      endcase
      if (!err && phase != PhHdr && phase != PhDone && byte_pos >= rec_len) phase = PhDone;
    end
    if (req.chunk_end) begin
      r.status_valid = 1'b1;
      if (err) r.parse_status = StError;
      else if (phase == PhDone) r.parse_status = name_done ? StNameFound : StNoName;
      else r.parse_status = StIncomplete;
    end
    return r;
  endfunction

  // input side: predict on acceptance, drive at falling edge
  logic in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_results.push_back(sni_predict(in_data_i));
      n_requests++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_requests.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 23) &&
          !(idle_mode == 1 && $urandom_range(99) < 80)) begin
        in_data_i <= pending_requests.pop_front();
        in_valid_i <= 1'b1;
      end else in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!held_off && n_requests >= 120) begin
      held_off <= 1'b1;
      stall_run <= 300;
      out_stall_i <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else
      out_stall_i <= (idle_mode == 0) ? ($urandom_range(99) < 80) :
                     (idle_mode == 1) ? ($urandom_range(99) < 23) : 1'b0;
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.name_last) n_names++;
        if (e.name_byte !== out_data_o.name_byte || e.name_valid !== out_data_o.name_valid ||
            e.name_last !== out_data_o.name_last ||
            e.status_valid !== out_data_o.status_valid ||
            e.parse_status !== out_data_o.parse_status) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("tls_hello_sni_extractor_unit test failed");
      $finish;
    end
  end

  task automatic queue_flow(input logic [7:0] q[$]);
    in_item_t it;
    foreach (q[i]) begin
      it.data_byte = q[i];
      it.flow_start = (i == 0) || ($urandom_range(199) == 0);
      it.chunk_end = (i == q.size() - 1) ? 1'($urandom_range(1)) : ($urandom_range(5) == 0);
      pending_requests.push_back(it);
    end
  endtask

  task automatic add_rand(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom));
  endtask

  task automatic set_lengths(ref logic [7:0] q[$]);
    int l;
    l = q.size() - 5;
    q[3] = 8'(l >> 8);
    q[4] = 8'(l);
    l = q.size() - 9;
    q[6] = 8'(l >> 16); q[7] = 8'(l >> 8); q[8] = 8'(l);
  endtask

  task automatic mangle(ref logic [7:0] q[$]);
    int k;
    case ($urandom_range(9))
      0: q[$urandom_range(q.size() - 1)] = 8'($urandom);
      1: begin
        k = $urandom_range(q.size() - 1);
        while (q.size() > k) void'(q.pop_back());
        if (q.size() == 0) q.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic client_hello(input int nlen, input bit zero_ext, input bit other_ext,
                              input logic [7:0] ntype, input bit clean);
    logic [7:0] q[$];
    logic [7:0] e[$];
    int n;
    q = {ContentHandshake, 8'h03, 8'h01, 8'h00, 8'h00, HsClientHello, 8'h00, 8'h00, 8'h00};
    add_rand(q, 34);
    n = $urandom_range(32); q.push_back(8'(n)); add_rand(q, n);
    n = 2 * $urandom_range(1, 8); q.push_back(8'(n >> 8)); q.push_back(8'(n)); add_rand(q, n);
    n = $urandom_range(1, 3); q.push_back(8'(n)); add_rand(q, n);
    if (!zero_ext) begin
      if (other_ext) begin
        n = $urandom_range(6);
        e.push_back(8'($urandom_range(1, 255))); e.push_back(8'($urandom));
        e.push_back(8'h00); e.push_back(8'(n)); add_rand(e, n);
      end
      e.push_back(8'h00); e.push_back(8'h00);
      e.push_back(8'((nlen + 5) >> 8)); e.push_back(8'(nlen + 5));
      e.push_back(8'((nlen + 3) >> 8)); e.push_back(8'(nlen + 3));
      e.push_back(ntype); e.push_back(8'(nlen >> 8)); e.push_back(8'(nlen));
      add_rand(e, nlen);
    end
    q.push_back(8'(e.size() >> 8)); q.push_back(8'(e.size()));
    q = {q, e};
    set_lengths(q);
    if (!clean) mangle(q);
    queue_flow(q);
  endtask

  task automatic cert_names(input logic [7:0] hs, input int names, input int nlen,
                            input bit clean);
    logic [7:0] q[$];
    q = {ContentHandshake, 8'h03, 8'h03, 8'h00, 8'h00, hs, 8'h00, 8'h00, 8'h00};
    repeat (names) begin
      add_rand(q, $urandom_range(8));
      q = {q, 8'h55, 8'h04, OidLast, 8'h0c, 8'(nlen)};
      add_rand(q, nlen);
    end
    add_rand(q, $urandom_range(4));
    set_lengths(q);
    if (!clean) mangle(q);
    queue_flow(q);
  endtask

  task automatic noise_flow();
    logic [7:0] q[$];
    add_rand(q, $urandom_range(1, 12));
    if ($urandom_range(1)) q[0] = ContentHandshake;
    queue_flow(q);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CfgMaxRecordLen) lim_record = val;
    else lim_name = val[11:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_mix(input int target);
    int goal;
    int k;
    goal = pending_requests.size() + target;
    while (pending_requests.size() < goal) begin
      k = $urandom_range(9);
      if (k < 5)
        client_hello(($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 24),
                     $urandom_range(19) == 0, $urandom_range(1) == 1,
                     ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00, $urandom_range(3) != 0);
      else if (k < 8)
        cert_names(($urandom_range(1)) ? HsServerHello : HsCertificate, $urandom_range(1, 2),
                   $urandom_range(24), $urandom_range(3) != 0);
      else noise_flow();
    end
  endtask

  initial begin
    logic [7:0] q[$];
    lim_record = MaxRecordLenRst;
    lim_name = MaxNameLenRst;
    clear_parser();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wrong content type, short record, other handshake type, empty and odd extensions
    q = {8'hff}; queue_flow(q);
    q = {8'h00, 8'h80}; queue_flow(q);
    q = {ContentHandshake, 8'h03, 8'h01, 8'h00, 8'h03}; queue_flow(q);
    q = {ContentHandshake, 8'h03, 8'h01, 8'h00, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00};
    queue_flow(q);
    client_hello(4, 1'b1, 1'b0, 8'h00, 1'b1);
    client_hello(3, 1'b0, 1'b1, 8'h01, 1'b1);
    client_hello(0, 1'b0, 1'b0, 8'h00, 1'b1);
    random_mix(120);
    drain();

    idle_mode = 0;
    write_reg(CfgMaxRecordLen, 15'd16389);
    write_reg(CfgMaxNameLen, 15'd4095);
    random_mix(110);
    drain();

    idle_mode = 1;
    write_reg(CfgMaxRecordLen, 15'd9);
    write_reg(CfgMaxNameLen, 15'd1);
    random_mix(45);
    drain();
    write_reg(CfgMaxRecordLen, 15'd120);
    write_reg(CfgMaxNameLen, 15'd12);
    random_mix(100);
    drain();

    idle_mode = 2;
    write_reg(CfgMaxRecordLen, 15'd5);
    write_reg(CfgMaxNameLen, 15'd0);
    random_mix(35);
    drain();
    write_reg(CfgMaxRecordLen, 15'h7fff);
    write_reg(CfgMaxNameLen, 15'd255);
    random_mix(200);
    drain();

    $display("covered %0d requests and %0d results, %0d complete names, across",
             n_requests, n_results, n_names);
    $display("six register settings, three idling mixes and one long output hold-off");
    if (errors == 0) $display("tls_hello_sni_extractor_unit test passed");
    else $display("tls_hello_sni_extractor_unit test failed");
    $finish;
  end

endmodule
